### sv/ola_pkg.sv
// ola_pkg: shared types and constants for the ordered array list engine
// command, status and sequencer state codes; no dependencies

package ola_pkg;

    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 8;

    // command codes carried by the operation field
    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_RM_INDEX  = 3'd2,
        OP_RM_FIRST  = 3'd3,
        OP_RM_ALL    = 3'd4,
        OP_UPDATE    = 3'd5,
        OP_READ      = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT,
        S_SCAN,
        S_READ_WAIT,
        S_DONE
    } state_t;

endpackage

### sv/ordered_array_list_engine.sv
// ordered_array_list_engine: ordered list of signed words kept in one synchronous memory
// depends on ola_pkg for command, status and state codes
//
//   channel  handshake         payload                                         word
//   s_       s_valid s_ready   s_operation s_position s_value                  command in
//   m_       m_valid m_ready   m_status m_read_value m_removed_count m_list_length  result out
//
// one command at a time: append, update, clear and index or fullness failures go from
// S_EXEC straight to S_DONE, read passes through S_READ_WAIT; insert shifts the entries
// from the top down to its position and the removes scan from their start to the end,
// one entry moving per cycle (remove at index starts at its position, the value removes at 0)
// reset clears the length and control state only; the memory needs no clearing pass
// a result waiting on m_ready holds the sequencer in its last state, s_ready stays low

module ordered_array_list_engine
    import ola_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [CNT_W-1:0]         m_removed_count,
    output logic [CNT_W-1:0]         m_list_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // list store
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]     used_count_reg, used_count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     ri_reg, ri_next;
    logic [AW-1:0]     wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    status_t           res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_read_reg, res_read_next;
    logic [CW-1:0]     res_removed_reg, res_removed_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_read_value_reg, m_read_value_next;
    logic [CNT_W-1:0]  m_removed_reg, m_removed_next;
    logic [CNT_W-1:0]  m_length_reg, m_length_next;

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     used_x;
    logic              keep;

    assign pos_x  = XW'(pos_reg);
    assign used_x = XW'(used_count_reg);

    // address of the entry just below a shift target
    function automatic logic [AW-1:0] idx_next_addr(input logic [CW-1:0] idx);
        logic [CW-1:0] below;
        below = idx - CW'(1);
        return below[AW-1:0];
    endfunction

    // memory write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // memory read port, registered data
    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // keep decision for the word read back during a scan
    always_comb begin
        case (op_reg)
            OP_RM_INDEX: keep = (XW'(ri_reg) != pos_x);
            OP_RM_FIRST: keep = !((rd_data_reg == val_reg) && !hit_reg);
            default:     keep = (rd_data_reg != val_reg);
        endcase
    end

    // sequencer: next state and datapath control
    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        used_count_next   = used_count_reg;
        idx_next          = idx_reg;
        wp_next           = wp_reg;
        ri_next           = ri_reg;
        wa_next           = wa_reg;
        pend_next         = pend_reg;
        hit_next          = hit_reg;
        res_status_next   = res_status_reg;
        res_read_next     = res_read_reg;
        res_removed_next  = res_removed_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_read_value_next = m_read_value_reg;
        m_removed_next    = m_removed_reg;
        m_length_next     = m_length_reg;
        mem_we            = 1'b0;
        mem_wa            = '0;
        mem_wd            = val_reg;
        mem_re            = 1'b0;
        mem_ra            = '0;
        s_ready           = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = op_t'(s_operation);
                    pos_next   = s_position;
                    val_next   = s_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_status_next  = ST_OK;
                res_read_next    = '0;
                res_removed_next = '0;
                state_next       = S_DONE;
                unique case (op_reg)
                    OP_APPEND: begin
                        if (used_count_reg >= CAP_C) begin
                            res_status_next = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wa          = used_count_reg[AW-1:0];
                            used_count_next = used_count_reg + CW'(1);
                        end
                    end
                    OP_INSERT: begin
                        if (pos_x > used_x) begin
                            res_status_next = ST_BAD_INDEX;
                        end else if (used_count_reg >= CAP_C) begin
                            res_status_next = ST_FULL;
                        end else begin
                            idx_next   = used_count_reg;
                            pend_next  = 1'b0;
                            state_next = S_INSERT;
                        end
                    end
                    OP_RM_INDEX: begin
                        if (pos_x >= used_x) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            idx_next   = CW'(pos_x);
                            wp_next    = CW'(pos_x);
                            pend_next  = 1'b0;
                            hit_next   = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    OP_RM_FIRST, OP_RM_ALL: begin
                        idx_next   = '0;
                        wp_next    = '0;
                        pend_next  = 1'b0;
                        hit_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                    OP_UPDATE: begin
                        if (pos_x >= used_x) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = pos_x[AW-1:0];
                        end
                    end
                    OP_READ: begin
                        if (pos_x >= used_x) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            mem_re     = 1'b1;
                            mem_ra     = pos_x[AW-1:0];
                            state_next = S_READ_WAIT;
                        end
                    end
                    OP_CLEAR: begin
                        res_removed_next = used_count_reg;
                        used_count_next  = '0;
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end

            // shift entries up one place, top first, then drop the new word in
            S_INSERT: begin
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = wa_reg;
                    mem_wd = rd_data_reg;
                end else if (XW'(idx_reg) == pos_x) begin
                    mem_we          = 1'b1;
                    mem_wa          = pos_x[AW-1:0];
                    used_count_next = used_count_reg + CW'(1);
                    state_next      = S_DONE;
                end
                if (XW'(idx_reg) > pos_x) begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_next_addr(idx_reg);
                    wa_next   = idx_reg[AW-1:0];
                    idx_next  = idx_reg - CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end

            // compaction pass: read ahead, write kept words behind
            S_SCAN: begin
                if (pend_reg) begin
                    if (keep) begin
                        mem_we  = 1'b1;
                        mem_wa  = wp_reg[AW-1:0];
                        mem_wd  = rd_data_reg;
                        wp_next = wp_reg + CW'(1);
                    end else begin
                        hit_next = 1'b1;
                    end
                end
                if (idx_reg < used_count_reg) begin
                    mem_re    = 1'b1;
                    mem_ra    = idx_reg[AW-1:0];
                    ri_next   = idx_reg;
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_removed_next = used_count_reg - wp_reg;
                        used_count_next  = wp_reg;
                        if (wp_reg == used_count_reg) begin
                            res_status_next = ST_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_READ_WAIT: begin
                res_read_next = rd_data_reg;
                state_next    = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_read_value_next = res_read_reg;
                    m_removed_next    = CNT_W'(res_removed_reg);
                    m_length_next     = CNT_W'(used_count_reg);
                    state_next        = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        pos_reg          <= pos_next;
        val_reg          <= val_next;
        idx_reg          <= idx_next;
        wp_reg           <= wp_next;
        ri_reg           <= ri_next;
        wa_reg           <= wa_next;
        res_status_reg   <= res_status_next;
        res_read_reg     <= res_read_next;
        res_removed_reg  <= res_removed_next;
        m_status_reg     <= m_status_next;
        m_read_value_reg <= m_read_value_next;
        m_removed_reg    <= m_removed_next;
        m_length_reg     <= m_length_next;
    end

    // result word outputs
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_removed_count = m_removed_reg;
    assign m_list_length   = m_length_reg;

endmodule

### tb/sv/ola_list_checker.sv
// ola_list_checker: watches the command and result channels of the ordered list engine,
// keeps its own copy of the list, predicts each result word and compares it field by field
// depends on ola_pkg for command and status codes and the port widths

module ola_list_checker
    import ola_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [1:0]               m_status,
    input  logic signed [DATA_W-1:0] m_read_value,
    input  logic [CNT_W-1:0]         m_removed_count,
    input  logic [CNT_W-1:0]         m_list_length,
    output int unsigned              mismatch_count,
    output int unsigned              awaited_count,
    output int unsigned              held_length
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  removed;
        logic [CNT_W-1:0]  length;
    } list_result_t;

    logic [DATA_W-1:0] list_words [CAPACITY];
    int unsigned       list_used;
    list_result_t      awaited_results [$];
    list_result_t      oldest_result;

    // drop the entry at idx, later entries move down one place
    function automatic void close_gap(input int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < list_used; i++)
            list_words[i] = list_words[i + 1];
        list_used--;
    endfunction

    // carry out one command on the list copy and return the result word it gives
    function automatic list_result_t apply_list_command(input op_t op,
                                                        input int unsigned pos,
                                                        input logic [DATA_W-1:0] val);
        list_result_t res;
        int unsigned  i;
        int unsigned  hit;
        int unsigned  keep;
        res.status     = ST_OK;
        res.read_value = '0;
        res.removed    = '0;
        case (op)
            OP_APPEND: begin
                if (list_used >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_used] = val;
                    list_used++;
                end
            end
            OP_INSERT: begin
                // index is checked before fullness
                if (pos > list_used) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_used >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_used; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = val;
                    list_used++;
                end
            end
            OP_RM_INDEX: begin
                if (pos >= list_used) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    close_gap(pos);
                    res.removed = CNT_W'(1);
                end
            end
            OP_RM_FIRST: begin
                hit = list_used;
                for (i = 0; i < list_used; i++)
                    if (hit == list_used && list_words[i] == val)
                        hit = i;
                if (hit == list_used) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    close_gap(hit);
                    res.removed = CNT_W'(1);
                end
            end
            OP_RM_ALL: begin
                // single compaction pass over the whole list
                keep = 0;
                for (i = 0; i < list_used; i++) begin
                    if (list_words[i] != val) begin
                        list_words[keep] = list_words[i];
                        keep++;
                    end
                end
                res.removed = CNT_W'(list_used - keep);
                if (keep == list_used)
                    res.status = ST_NOT_FOUND;
                list_used = keep;
            end
            OP_UPDATE: begin
                if (pos >= list_used)
                    res.status = ST_BAD_INDEX;
                else
                    list_words[pos] = val;
            end
            OP_READ: begin
                if (pos >= list_used)
                    res.status = ST_BAD_INDEX;
                else
                    res.read_value = list_words[pos];
            end
            default: begin
                res.removed = CNT_W'(list_used);
                list_used   = 0;
            end
        endcase
        res.length = CNT_W'(list_used);
        return res;
    endfunction

    // compare result words first, then record the command word of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_used = 0;
            awaited_results.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result word with no command waiting:", $realtime,
                                 " status %0d read %h removed %0d length %0d",
                                 m_status, m_read_value, m_removed_count,
                                 m_list_length);
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (m_status !== oldest_result.status
                            || m_read_value !== oldest_result.read_value
                            || m_removed_count !== oldest_result.removed
                            || m_list_length !== oldest_result.length) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: result mismatch:", $realtime,
                                     " expected status %0d read %h removed %0d length %0d,",
                                     oldest_result.status, oldest_result.read_value,
                                     oldest_result.removed, oldest_result.length,
                                     " got status %0d read %h removed %0d length %0d",
                                     m_status, m_read_value, m_removed_count,
                                     m_list_length);
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(apply_list_command(op_t'(s_operation),
                                                             32'(s_position), s_value));
        end
        awaited_count = awaited_results.size();
        held_length   = list_used;
    end

endmodule

### tb/sv/tb_ordered_array_list_engine.sv
// tb_ordered_array_list_engine: drives command words into the ordered list engine and
// paces the result channel; the verdict comes from ola_list_checker's mismatch count
// depends on ola_pkg, ordered_array_list_engine and ola_list_checker

module tb_ordered_array_list_engine
    import ola_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 128;
    localparam int ITEM_TARGET  = 1450;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_operation = OP_APPEND;
    logic [POS_W-1:0]         s_position = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_read_value;
    logic [CNT_W-1:0]         m_removed_count;
    logic [CNT_W-1:0]         m_list_length;

    int unsigned mismatch_count;
    int unsigned awaited_count;
    int unsigned held_length;

    // stimulus pacing and shaping state
    int unsigned       words_sent = 0;
    int unsigned       len_seen = 0;
    int unsigned       send_idle_pct = 8;
    int unsigned       recv_idle_pct = 81;
    bit                hold_request = 1'b0;
    bit                hold_issued = 1'b0;
    logic [DATA_W-1:0] value_pool [8];
    int unsigned       pool_size = 1;

    ordered_array_list_engine #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_value   (m_read_value),
        .m_removed_count(m_removed_count),
        .m_list_length  (m_list_length)
    );

    ola_list_checker #(
        .CAPACITY(CAPACITY)
    ) list_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_value   (m_read_value),
        .m_removed_count(m_removed_count),
        .m_list_length  (m_list_length),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count),
        .held_length    (held_length)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // list length as the checker sees it, taken away from the active edge
    always @(negedge aclk) begin
        len_seen <= held_length;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        logic        take;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                take = ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge aclk);
            m_ready <= take;
        end
    end

    // offer one command word, with random idle cycles in front, and wait for acceptance
    task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        words_sent++;
    endtask

    // mostly values from the current pool so searches find matches
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 80)
            return value_pool[$urandom_range(pool_size - 1)];
        return $urandom;
    endfunction

    // mostly a position inside the list, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(input op_t op);
        int unsigned hi_idx;
        if ($urandom_range(99) < 12)
            return POS_W'($urandom_range(127));
        if (op == OP_INSERT)
            hi_idx = len_seen;
        else
            hi_idx = (len_seen == 0) ? 0 : len_seen - 1;
        if (hi_idx > 127)
            hi_idx = 127;
        return POS_W'($urandom_range(hi_idx, 0));
    endfunction

    function automatic op_t pick_operation();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return OP_APPEND;
        if (roll < 40)
            return OP_INSERT;
        if (roll < 52)
            return OP_RM_INDEX;
        if (roll < 64)
            return OP_RM_FIRST;
        if (roll < 70)
            return OP_RM_ALL;
        if (roll < 82)
            return OP_UPDATE;
        if (roll < 97)
            return OP_READ;
        return OP_CLEAR;
    endfunction

    // stimulus and verdict
    initial begin
        int unsigned kind;
        int unsigned span;
        int unsigned n;
        op_t         op;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list corner cases
        send_word(OP_READ, 7'd0, 32'd0);
        send_word(OP_RM_INDEX, 7'd0, 32'd0);
        send_word(OP_UPDATE, 7'd0, 32'd5);
        send_word(OP_RM_FIRST, 7'd0, 32'd0);
        send_word(OP_RM_ALL, 7'd0, 32'd0);
        send_word(OP_CLEAR, 7'd0, 32'd0);
        send_word(OP_INSERT, 7'd1, 32'd9);
        // directed: value extremes, insert at front, middle and end
        send_word(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_word(OP_APPEND, 7'd127, 32'h8000_0000);
        send_word(OP_APPEND, 7'd0, 32'h0000_0000);
        send_word(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 7'd4, 32'h8000_0000);
        send_word(OP_INSERT, 7'd2, 32'h1234_5678);
        // directed: reads at the last entry, just past it and at the top index
        send_word(OP_READ, 7'd5, 32'd0);
        send_word(OP_READ, 7'd6, 32'd0);
        send_word(OP_READ, 7'd127, 32'd0);
        send_word(OP_UPDATE, 7'd0, 32'hA5A5_A5A5);
        // directed: first match among duplicates, miss, remove all duplicates
        send_word(OP_RM_FIRST, 7'd0, 32'h8000_0000);
        send_word(OP_RM_FIRST, 7'd0, 32'h0000_5555);
        send_word(OP_APPEND, 7'd0, 32'h0000_0000);
        send_word(OP_RM_ALL, 7'd0, 32'h0000_0000);
        send_word(OP_RM_INDEX, 7'd0, 32'd0);
        send_word(OP_RM_INDEX, 7'd127, 32'd0);
        send_word(OP_RM_ALL, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 7'd0, 32'd0);

        // random episodes: fill to full, mixed traffic, draining
        while (words_sent < ITEM_TARGET) begin
            if (words_sent < ITEM_TARGET / 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 81;
            end else if (words_sent < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 81;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_issued) begin
                    hold_request = 1'b1;
                    hold_issued  = 1'b1;
                end
            end

            // fresh value pool, sometimes a single value
            pool_size = $urandom_range(1, 8);
            for (n = 0; n < 8; n++) begin
                case ($urandom_range(7))
                    0: value_pool[n] = 32'h7FFF_FFFF;
                    1: value_pool[n] = 32'h8000_0000;
                    2: value_pool[n] = '0;
                    3: value_pool[n] = '1;
                    default: value_pool[n] = $urandom;
                endcase
            end

            kind = $urandom_range(99);
            if (kind < 30) begin
                // grow to full and push a few more against the limit
                span = CAPACITY - len_seen + $urandom_range(2, 6);
                repeat (span) begin
                    if ($urandom_range(9) < 7)
                        send_word(OP_APPEND, POS_W'($urandom_range(127)), pick_value());
                    else
                        send_word(OP_INSERT, pick_position(OP_INSERT), pick_value());
                end
            end else if (kind < 80) begin
                repeat ($urandom_range(20, 60)) begin
                    op = pick_operation();
                    send_word(op, pick_position(op), pick_value());
                end
            end else begin
                repeat ($urandom_range(4, 16)) begin
                    case ($urandom_range(2))
                        0: send_word(OP_RM_ALL, POS_W'($urandom_range(127)), pick_value());
                        1: send_word(OP_RM_FIRST, POS_W'($urandom_range(127)), pick_value());
                        default: send_word(OP_RM_INDEX, pick_position(OP_RM_INDEX), $urandom);
                    endcase
                end
                if ($urandom_range(1))
                    send_word(OP_CLEAR, POS_W'($urandom_range(127)), $urandom);
            end
        end
        s_valid <= 1'b0;

        // let outstanding result words drain, then settle
        do @(negedge aclk); while (awaited_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog on cycles with no word accepted on either channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
sv/ola_pkg.sv
sv/ordered_array_list_engine.sv
tb/sv/ola_list_checker.sv
tb/sv/tb_ordered_array_list_engine.sv
